// ----- hdl/i2cmts_pkg.sv -----
// i2cmts_pkg: request and result types, status codes and control bits
// for the two-wire master transaction sequencer
// no dependencies
`default_nettype none

package i2cmts_pkg;

  typedef struct packed {
    logic [7:0] bus_status;
    logic [7:0] control_in;
    logic [7:0] rx_byte;
    logic [7:0] next_trans_size;
    logic [7:0] next_trans_addr_byte;
    logic [7:0] next_trans_tag;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } i2cmts_req_t;

  typedef struct packed {
    logic [7:0] control_out;
    logic       data_write_valid;
    logic [7:0] data_out;
    logic       trans_pop;
    logic       tx_pop;
    logic [7:0] tx_discard_count;
    logic       rx_push_valid;
    logic [7:0] rx_push_byte;
    logic       done_valid;
    logic [7:0] done_tag;
    logic [7:0] done_count;
    logic       bus_active;
  } i2cmts_res_t;

  // control register bits
  localparam logic [7:0] CTL_STA = 8'h20;
  localparam logic [7:0] CTL_STO = 8'h10;
  localparam logic [7:0] CTL_EA  = 8'h40;

  // status field, upper five bits only
  localparam logic [7:0] STATUS_MASK = 8'hF8;

  // bus status codes
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_REP_START    = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

endpackage

`default_nettype wire

// ----- hdl/i2c_master_transaction_sequencer_core.sv -----
// i2c_master_transaction_sequencer_core: per-event decision logic of a
// two-wire bus master that walks a queue of transactions
// depends on i2cmts_pkg
//
// usage
// - in_valid / in_stall / in_req carry one bus status event as a request,
//   together with the control byte, the received byte, the head of the
//   pending-transaction queue and the head of the transmit byte queue
// - out_valid / out_stall / out_res carry exactly one result per request:
//   new control byte, data register write, queue pops, receive push,
//   transmit discard count and a completion report
// - a request is held in an input register, decided in one pass of
//   combinational logic and lands in the result register
// - one request per cycle is taken for as long as results are drained;
//   the transaction state (size, address, tag, count, bus flag) is updated
//   as a request moves into the result register, so the next request
//   already sees it
// - while out_stall is high the result register holds; one more request
//   may wait in the input register, after which in_stall rises
// - synchronous active-low reset empties both registers and clears the
//   transaction state
`default_nettype none

module i2c_master_transaction_sequencer_core #(
  parameter int MAX_TRANSACTION_BYTES = 255
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  i2cmts_pkg::i2cmts_req_t  in_req,
  output logic                     out_valid,
  input  wire                      out_stall,
  output i2cmts_pkg::i2cmts_res_t  out_res
);

  import i2cmts_pkg::*;

  // byte counter saturates here, never above what eight bits hold
  localparam logic [7:0] CountCap =
    (MAX_TRANSACTION_BYTES > 255) ? 8'd255 : 8'(MAX_TRANSACTION_BYTES);

  // input register
  logic        s1_valid_r;
  i2cmts_req_t s1_req_r;

  // result register
  logic        out_valid_r;
  i2cmts_res_t out_res_r;

  // active transaction state
  logic [7:0] active_size_r,      active_size_nxt;
  logic [7:0] active_addr_byte_r, active_addr_byte_nxt;
  logic [7:0] active_tag_r,       active_tag_nxt;
  logic [7:0] byte_count_r,       byte_count_nxt;
  logic       active_flag_r,      active_flag_nxt;

  i2cmts_res_t res_nxt;
  logic        advance;

  // request moves on when the result register is free or being emptied
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // decision logic for the request in the input register
  always_comb begin
    logic [7:0] status;
    logic [7:0] ctl;
    logic [7:0] bc_inc;
    logic       do_finish;
    logic [7:0] fin_count;

    status    = s1_req_r.bus_status & STATUS_MASK;
    ctl       = s1_req_r.control_in;
    bc_inc    = (byte_count_r < CountCap) ? byte_count_r + 8'd1 : byte_count_r;
    do_finish = 1'b0;
    fin_count = byte_count_r;

    res_nxt              = '0;
    active_size_nxt      = active_size_r;
    active_addr_byte_nxt = active_addr_byte_r;
    active_tag_nxt       = active_tag_r;
    byte_count_nxt       = byte_count_r;
    active_flag_nxt      = active_flag_r;

    case (status)
      ST_START, ST_REP_START: begin
        // a fresh start loads the queue head; a repeated start was loaded
        // when the previous transaction finished
        if (status == ST_START) begin
          byte_count_nxt = '0;
          if (s1_req_r.next_trans_size != 8'd0) begin
            active_size_nxt      = s1_req_r.next_trans_size;
            active_addr_byte_nxt = s1_req_r.next_trans_addr_byte;
            active_tag_nxt       = s1_req_r.next_trans_tag;
            res_nxt.trans_pop    = 1'b1;
          end else begin
            active_size_nxt = '0;
          end
        end
        ctl = ctl & ~CTL_STA;
        if (active_size_nxt == 8'd0) begin
          // nothing queued, release the bus
          ctl             = ctl | CTL_STO;
          active_flag_nxt = 1'b0;
        end else begin
          active_flag_nxt          = 1'b1;
          res_nxt.data_write_valid = 1'b1;
          res_nxt.data_out         = active_addr_byte_nxt;
        end
      end
      ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
        if (byte_count_r < active_size_r) begin
          // an empty transmit queue still advances the count
          if (s1_req_r.tx_valid) begin
            res_nxt.tx_pop           = 1'b1;
            res_nxt.data_write_valid = 1'b1;
            res_nxt.data_out         = s1_req_r.tx_byte;
          end
          byte_count_nxt = bc_inc;
        end else begin
          do_finish = 1'b1;
        end
      end
      ST_MR_SLA_ACK: begin
        // single-byte read answers its only byte with nack
        if (active_size_r > 8'd1) ctl = ctl | CTL_EA;
        else                      ctl = ctl & ~CTL_EA;
      end
      ST_MR_DATA_ACK: begin
        res_nxt.rx_push_valid = 1'b1;
        res_nxt.rx_push_byte  = s1_req_r.rx_byte;
        byte_count_nxt        = bc_inc;
        if (active_size_r > bc_inc && (active_size_r - bc_inc) == 8'd1) begin
          ctl = ctl & ~CTL_EA;
        end else if (active_size_r == bc_inc) begin
          do_finish = 1'b1;
          fin_count = bc_inc;
        end
      end
      ST_MR_DATA_NACK: begin
        // last byte of a read is stored and counted
        res_nxt.rx_push_valid = 1'b1;
        res_nxt.rx_push_byte  = s1_req_r.rx_byte;
        do_finish             = 1'b1;
        fin_count             = bc_inc;
      end
      ST_MR_SLA_NACK: begin
        do_finish = 1'b1;
      end
      ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_ARB_LOST: begin
        res_nxt.tx_discard_count = (active_size_r > byte_count_r) ?
                                   active_size_r - byte_count_r : 8'd0;
        do_finish = 1'b1;
      end
      default: begin
        ctl             = ctl | CTL_STO;
        active_flag_nxt = 1'b0;
      end
    endcase

    // completion: report, then chain to the next queued transaction by
    // repeated start or release the bus
    if (do_finish) begin
      res_nxt.done_valid = 1'b1;
      res_nxt.done_tag   = active_tag_r;
      res_nxt.done_count = fin_count;
      byte_count_nxt     = '0;
      if (s1_req_r.next_trans_size != 8'd0) begin
        active_size_nxt      = s1_req_r.next_trans_size;
        active_addr_byte_nxt = s1_req_r.next_trans_addr_byte;
        active_tag_nxt       = s1_req_r.next_trans_tag;
        res_nxt.trans_pop    = 1'b1;
        ctl                  = ctl | CTL_STA;
      end else begin
        active_size_nxt = '0;
        ctl             = ctl | CTL_STO;
        active_flag_nxt = 1'b0;
      end
    end

    res_nxt.control_out = ctl;
    res_nxt.bus_active  = active_flag_nxt;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r <= in_req;
    end
  end

  // result register and transaction state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r        <= 1'b0;
      active_size_r      <= '0;
      active_addr_byte_r <= '0;
      active_tag_r       <= '0;
      byte_count_r       <= '0;
      active_flag_r      <= 1'b0;
    end else if (advance) begin
      out_valid_r        <= 1'b1;
      active_size_r      <= active_size_nxt;
      active_addr_byte_r <= active_addr_byte_nxt;
      active_tag_r       <= active_tag_nxt;
      byte_count_r       <= byte_count_nxt;
      active_flag_r      <= active_flag_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/i2cmts_checker.sv -----
// i2cmts_checker: port-level checks on the sequencer results, bound to
// the sequencer core; depends on i2cmts_pkg
`default_nettype none

module i2cmts_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      out_valid,
  input wire                      out_stall,
  input i2cmts_pkg::i2cmts_res_t  out_res
);

  import i2cmts_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

  // no data byte without a data write
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.data_write_valid || out_res.data_out == 8'd0))
    else $error("data byte without data write");

  // completion fields only with a completion
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.done_valid |->
      (out_res.done_tag == 8'd0 && out_res.done_count == 8'd0))
    else $error("completion fields without completion");

  // a popped transaction is either addressed now or started again
  a_pop_use: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.trans_pop |->
      (out_res.data_write_valid || (out_res.control_out & CTL_STA) != 8'd0))
    else $error("transaction popped but not used");

  // discarding transmit bytes only ever ends a transaction
  a_discard_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.tx_discard_count != 8'd0 |-> out_res.done_valid)
    else $error("discard without completion");

endmodule

bind i2c_master_transaction_sequencer_core i2cmts_checker u_i2cmts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);

`default_nettype wire

// ----- bench/testbench.sv -----
// testbench: self-checking bench for i2c_master_transaction_sequencer_core
// a directed table followed by random transaction sequences, checked against a local predictor
// depends on i2cmts_pkg and the core under hdl/

module testbench;
  import i2cmts_pkg::*;

  localparam int MAX_BYTES    = 255;
  localparam int COUNT_CAP    = (MAX_BYTES > 255) ? 255 : MAX_BYTES;
  localparam int RANDOM_ITEMS = 950;
  localparam int FLOOD_LEN    = 258;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 160;
  localparam int CYCLE_LIMIT  = 400000;

  // status values that match no bus state
  localparam logic [7:0] ST_UNKNOWN_LO = 8'h00;
  localparam logic [7:0] ST_UNKNOWN_HI = 8'hF8;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  i2cmts_req_t  in_req;
  logic         out_valid;
  logic         out_stall;
  i2cmts_res_t  out_res;

  i2c_master_transaction_sequencer_core #(
    .MAX_TRANSACTION_BYTES(MAX_BYTES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  // period of 2
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // request list: every request in the order it is offered; rows of the
  // directed table may carry a hand-written result that replaces the prediction
  // ---------------------------------------------------------------------------
  i2cmts_req_t event_reqs[$];
  bit          event_typed[$];
  i2cmts_res_t event_fixed_res[$];

  // results predicted for accepted requests, oldest first
  i2cmts_res_t pending_results[$];

  // predictor copy of the transaction state
  logic [7:0] cur_size;
  logic [7:0] cur_addr;
  logic [7:0] cur_tag;
  logic [7:0] xfer_count;
  logic       bus_held;

  // shape of the transaction the generator is building
  logic [7:0] gen_sz;
  logic       gen_rd;
  bit         gen_chained;

  int errors;
  int acc_count;
  int res_count;
  int done_seen;
  int push_seen;
  int discard_seen;
  int n_directed;
  int n_total;
  int cycles;
  bit hold_done;

  i2cmts_res_t predicted;
  i2cmts_res_t oldest;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input int idx, input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %02h want %02h", idx, name, got, want));
  endtask

  task automatic check_result(input int idx, input i2cmts_res_t got, input i2cmts_res_t want);
    check_field(idx, "control_out",      got.control_out,      want.control_out);
    check_field(idx, "data_write_valid", 8'(got.data_write_valid),
                8'(want.data_write_valid));
    check_field(idx, "data_out",         got.data_out,         want.data_out);
    check_field(idx, "trans_pop",        8'(got.trans_pop),    8'(want.trans_pop));
    check_field(idx, "tx_pop",           8'(got.tx_pop),       8'(want.tx_pop));
    check_field(idx, "tx_discard_count", got.tx_discard_count, want.tx_discard_count);
    check_field(idx, "rx_push_valid",    8'(got.rx_push_valid), 8'(want.rx_push_valid));
    check_field(idx, "rx_push_byte",     got.rx_push_byte,     want.rx_push_byte);
    check_field(idx, "done_valid",       8'(got.done_valid),   8'(want.done_valid));
    check_field(idx, "done_tag",         got.done_tag,         want.done_tag);
    check_field(idx, "done_count",       got.done_count,       want.done_count);
    check_field(idx, "bus_active",       8'(got.bus_active),   8'(want.bus_active));
  endtask

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // take the head of the transaction queue, or note that it is empty
  function automatic void load_head(input i2cmts_req_t r, inout i2cmts_res_t res);
    xfer_count = 8'h00;
    if (r.next_trans_size != 8'h00) begin
      cur_size      = r.next_trans_size;
      cur_addr      = r.next_trans_addr_byte;
      cur_tag       = r.next_trans_tag;
      res.trans_pop = 1'b1;
    end else begin
      cur_size = 8'h00;
    end
  endfunction

  // completion report, then repeated start for a queued transaction or stop
  function automatic logic [7:0] wrap_up(input i2cmts_req_t r, inout i2cmts_res_t res,
                                         input logic [7:0] ctl);
    logic [7:0] c;
    c = ctl;
    res.done_valid = 1'b1;
    res.done_tag   = cur_tag;
    res.done_count = xfer_count;
    load_head(r, res);
    if (cur_size != 8'h00) begin
      c = c | CTL_STA;
    end else begin
      c        = c | CTL_STO;
      bus_held = 1'b0;
    end
    return c;
  endfunction

  // byte counter saturates at the cap
  function automatic void bump_count();
    if (int'(xfer_count) < COUNT_CAP) xfer_count = xfer_count + 8'd1;
  endfunction

  function automatic i2cmts_res_t predict_event(input i2cmts_req_t r);
    i2cmts_res_t res;
    logic [7:0]  st;
    logic [7:0]  ctl;
    res = '0;
    st  = r.bus_status & STATUS_MASK;
    ctl = r.control_in;
    case (st)
      ST_START, ST_REP_START: begin
        // only a fresh start loads the queue head; a repeated start uses
        // the transaction loaded when the previous one completed
        if (st == ST_START) load_head(r, res);
        bus_held = 1'b1;
        ctl      = ctl & ~CTL_STA;
        if (cur_size == 8'h00) begin
          ctl      = ctl | CTL_STO;
          bus_held = 1'b0;
        end else begin
          res.data_write_valid = 1'b1;
          res.data_out         = cur_addr;
        end
      end
      ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
        if (xfer_count < cur_size) begin
          // empty transmit queue: nothing written but the count moves on
          if (r.tx_valid) begin
            res.tx_pop           = 1'b1;
            res.data_write_valid = 1'b1;
            res.data_out         = r.tx_byte;
          end
          bump_count();
        end else begin
          ctl = wrap_up(r, res, ctl);
        end
      end
      ST_MR_SLA_ACK: begin
        // single-byte read must nack its only byte
        if (cur_size > 8'd1) ctl = ctl | CTL_EA;
        else                 ctl = ctl & ~CTL_EA;
      end
      ST_MR_DATA_ACK: begin
        res.rx_push_valid = 1'b1;
        res.rx_push_byte  = r.rx_byte;
        bump_count();
        if (cur_size > xfer_count && (cur_size - xfer_count) == 8'd1) ctl = ctl & ~CTL_EA;
        else if (cur_size == xfer_count) ctl = wrap_up(r, res, ctl);
      end
      ST_MR_DATA_NACK: begin
        // last byte is kept and counted before the report
        res.rx_push_valid = 1'b1;
        res.rx_push_byte  = r.rx_byte;
        bump_count();
        ctl = wrap_up(r, res, ctl);
      end
      ST_MR_SLA_NACK: begin
        ctl = wrap_up(r, res, ctl);
      end
      ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_ARB_LOST: begin
        res.tx_discard_count = (cur_size > xfer_count) ? (cur_size - xfer_count) : 8'h00;
        ctl = wrap_up(r, res, ctl);
      end
      default: begin
        ctl      = ctl | CTL_STO;
        bus_held = 1'b0;
      end
    endcase
    res.control_out = ctl;
    res.bus_active  = bus_held;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rnd8();
    return 8'($urandom());
  endfunction

  function automatic i2cmts_req_t mk_req(input logic [7:0] st, ctl, rx, sz, ad, tg,
                                         input logic txv, input logic [7:0] txb);
    i2cmts_req_t r;
    r.bus_status           = st;
    r.control_in           = ctl;
    r.rx_byte              = rx;
    r.next_trans_size      = sz;
    r.next_trans_addr_byte = ad;
    r.next_trans_tag       = tg;
    r.tx_valid             = txv;
    r.tx_byte              = txb;
    return r;
  endfunction

  task automatic add_row(input i2cmts_req_t r, input bit typed, input i2cmts_res_t res);
    event_reqs.push_back(r);
    event_typed.push_back(typed);
    event_fixed_res.push_back(res);
  endtask

  // mostly short transactions, now and then a longer one
  task automatic pick_shape();
    gen_rd = 1'($urandom_range(0, 1));
    gen_sz = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(7, 24))
                                          : 8'($urandom_range(1, 6));
  endtask

  // request whose queue head is the transaction just picked
  function automatic i2cmts_req_t head_req(input logic [7:0] st);
    return mk_req(st, rnd8(), rnd8(), gen_sz, {7'($urandom_range(0, 127)), gen_rd}, rnd8(),
                  1'($urandom_range(0, 1)), rnd8());
  endfunction

  // mid-transaction event; head fields are don't-care here
  task automatic add_plain(input logic [7:0] st);
    add_row(mk_req(st, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(),
                   1'($urandom_range(0, 9) != 0), rnd8()), 1'b0, '0);
  endtask

  // event that ends a transaction; half the time another one is queued
  task automatic add_finisher(input logic [7:0] st);
    if ($urandom_range(0, 1) != 0) begin
      pick_shape();
      add_row(head_req(st), 1'b0, '0);
      gen_chained = 1'b1;
    end else begin
      add_row(mk_req(st, rnd8(), rnd8(), 8'h00, rnd8(), rnd8(), 1'($urandom_range(0, 1)),
                     rnd8()), 1'b0, '0);
      gen_chained = 1'b0;
    end
  endtask

  // one well-formed transaction with occasional early failure
  task automatic gen_transaction();
    int         k;
    logic [7:0] sz;
    if (gen_chained) begin
      add_plain(ST_REP_START);
    end else begin
      pick_shape();
      add_row(head_req(ST_START), 1'b0, '0);
    end
    sz = gen_sz;
    if (gen_rd) begin
      if ($urandom_range(0, 19) == 0) begin
        add_finisher(($urandom_range(0, 1) != 0) ? ST_MR_SLA_NACK : ST_ARB_LOST);
        return;
      end
      add_plain(ST_MR_SLA_ACK);
      for (k = 1; k <= int'(sz); k++) begin
        if (k == int'(sz)) begin
          add_finisher(($urandom_range(0, 9) < 7) ? ST_MR_DATA_NACK : ST_MR_DATA_ACK);
        end else if ($urandom_range(0, 29) == 0) begin
          add_finisher(ST_MR_DATA_NACK);
          return;
        end else begin
          add_plain(ST_MR_DATA_ACK);
        end
      end
    end else begin
      for (k = 0; k <= int'(sz); k++) begin
        if (k == int'(sz)) begin
          add_finisher(ST_MT_DATA_ACK);
        end else if ($urandom_range(0, 24) == 0) begin
          if ($urandom_range(0, 2) == 0) add_finisher(ST_ARB_LOST);
          else add_finisher((k == 0) ? ST_MT_SLA_NACK : ST_MT_DATA_NACK);
          return;
        end else begin
          add_plain((k == 0) ? ST_MT_SLA_ACK : ST_MT_DATA_ACK);
        end
      end
    end
  endtask

  task automatic build_directed();
    // after reset: unknown status only raises stop
    add_row(mk_req(ST_UNKNOWN_LO, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1'b1,
            '{8'h10, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0});
    // start with nothing queued
    add_row(mk_req(ST_START, 8'h20, 8'h00, 8'h00, 8'h55, 8'h66, 1'b0, 8'h00), 1'b1,
            '{8'h10, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0});
    // three-byte write, one slot with the transmit queue empty
    add_row(mk_req(ST_START, 8'hA5, 8'h00, 8'h03, 8'hA0, 8'h11, 1'b0, 8'h00), 1'b1,
            '{8'h85, 1'b1, 8'hA0, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1});
    add_row(mk_req(ST_MT_SLA_ACK,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF), 1'b0, '0);
    add_row(mk_req(ST_MT_DATA_ACK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'hFF), 1'b0, '0);
    add_row(mk_req(ST_MT_DATA_ACK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00), 1'b0, '0);
    // write completes: count includes the empty slot, then stop
    add_row(mk_req(ST_MT_DATA_ACK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h77), 1'b1,
            '{8'h10, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 8'h11, 8'h03, 1'b0});
    // single-byte read: ack cleared, nacked byte stored, chained to a write
    add_row(mk_req(ST_START, 8'h20, 8'h00, 8'h01, 8'hA1, 8'h22, 1'b0, 8'h00), 1'b0, '0);
    add_row(mk_req(ST_MR_SLA_ACK, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1'b0, '0);
    add_row(mk_req(ST_MR_DATA_NACK, 8'h04, 8'h5A, 8'h02, 8'h31, 8'h33, 1'b0, 8'h00), 1'b1,
            '{8'h24, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 8'h5A, 1'b1, 8'h22, 8'h01, 1'b1});
    add_row(mk_req(ST_REP_START, 8'h24, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1'b0, '0);
    add_row(mk_req(ST_MT_SLA_ACK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h3C), 1'b0, '0);
    // write nack: one byte left to discard
    add_row(mk_req(ST_MT_DATA_NACK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1'b1,
            '{8'h10, 1'b0, 8'h00, 1'b0, 1'b0, 8'h01, 1'b0, 8'h00, 1'b1, 8'h33, 8'h01, 1'b0});
    // largest read, arbitration lost after one byte
    add_row(mk_req(ST_START, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00), 1'b0, '0);
    add_row(mk_req(ST_MR_SLA_ACK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1'b0, '0);
    add_row(mk_req(ST_MR_DATA_ACK, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1'b0, '0);
    add_row(mk_req(ST_ARB_LOST, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1'b1,
            '{8'h10, 1'b0, 8'h00, 1'b0, 1'b0, 8'hFE, 1'b0, 8'h00, 1'b1, 8'hFF, 8'h01, 1'b0});
    // address nacks with nothing active
    add_row(mk_req(ST_MR_SLA_NACK, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1'b0, '0);
    add_row(mk_req(ST_MT_SLA_NACK, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1'b0, '0);
    // start with low status bits set, two-byte read to completion by ack
    add_row(mk_req(ST_START | 8'h07, 8'hFF, 8'h00, 8'h02, 8'hA3, 8'h44, 1'b0, 8'h00),
            1'b0, '0);
    add_row(mk_req(ST_MR_SLA_ACK, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1'b0, '0);
    add_row(mk_req(ST_MR_DATA_ACK, 8'hFF, 8'h81, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1'b0, '0);
    add_row(mk_req(ST_MR_DATA_ACK, 8'h00, 8'h7E, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF), 1'b0, '0);
    // all ones: highest status is unknown
    add_row(mk_req(ST_UNKNOWN_HI | 8'h07, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF),
            1'b1,
            '{8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0});
  endtask

  task automatic build_random();
    int  k;
    bit  flooded;
    flooded     = 1'b0;
    gen_chained = 1'b0;
    while (event_reqs.size() < n_directed + RANDOM_ITEMS) begin
      if (!flooded && event_reqs.size() > n_directed + 450) begin
        // reads with nothing active count on until the counter saturates
        add_row(mk_req(ST_START, rnd8(), rnd8(), 8'h00, rnd8(), rnd8(), 1'b0, rnd8()),
                1'b0, '0);
        for (k = 0; k < FLOOD_LEN; k++) add_plain(ST_MR_DATA_ACK);
        add_finisher(ST_MR_DATA_NACK);
        flooded = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        // noise: anything at all, then restart from a clean start
        for (k = $urandom_range(1, 3); k > 0; k--)
          add_row(mk_req(rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(),
                         1'($urandom_range(0, 1)), rnd8()), 1'b0, '0);
        gen_chained = 1'b0;
      end
      gen_transaction();
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted request, checks every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted = predict_event(in_req);
        if (event_typed[acc_count]) predicted = event_fixed_res[acc_count];
        if (predicted.done_valid)              done_seen++;
        if (predicted.rx_push_valid)           push_seen++;
        if (predicted.tx_discard_count != 8'h00) discard_seen++;
        pending_results.push_back(predicted);
        acc_count++;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", res_count));
        end else begin
          oldest = pending_results.pop_front();
          check_result(res_count, out_res, oldest);
        end
        res_count++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stalls on a random 32-bit pattern in one of four densities,
  // and once holds off for a long stretch so the core backs up
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] pat_a;
    logic [31:0] pat_b;
    int          mode;
    int          k;
    out_stall <= 1'b0;
    hold_done = 1'b0;
    forever begin
      pat_a = $urandom();
      pat_b = $urandom();
      mode  = $urandom_range(0, 3);
      for (k = 0; k < 32; k++) begin
        @(posedge clk);
        if (!hold_done && acc_count >= HOLD_AT) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= pat_a[k];
          2:       out_stall <= pat_a[k] & pat_b[k];
          default: out_stall <= pat_a[k] | pat_b[k];
        endcase
      end
    end
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sender and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int idx;
    int burst;
    int gap;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    errors       = 0;
    acc_count    = 0;
    res_count    = 0;
    done_seen    = 0;
    push_seen    = 0;
    discard_seen = 0;
    cur_size     = 8'h00;
    cur_addr     = 8'h00;
    cur_tag      = 8'h00;
    xfer_count   = 8'h00;
    bus_held     = 1'b0;

    build_directed();
    n_directed = event_reqs.size();
    build_random();
    n_total = event_reqs.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bursts of back-to-back requests separated by random gaps; the request
    // is held unchanged while the core stalls it
    idx   = 0;
    burst = $urandom_range(1, 12);
    while (idx < n_total) begin
      in_valid <= 1'b1;
      in_req   <= event_reqs[idx];
      do @(posedge clk); while (in_stall);
      idx++;
      burst--;
      if (burst == 0 || idx == n_total) begin
        in_valid <= 1'b0;
        if (idx < n_total) begin
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
      end
    end

    // drain, then watch a little longer for stray results
    while (res_count < n_total) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests (%0d from the directed table), %0d results checked",
             acc_count, n_directed, res_count);
    $display("completion reports %0d, receive pushes %0d, transmit discards %0d",
             done_seen, push_seen, discard_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
